[hdl/mlaw_pkg.sv]
package mlaw_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int FORMAT_W   = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   localparam logic [15:0] MU_BIAS   = 16'h0084;
   localparam logic [15:0] MU_CLIP   = 16'd32635;
   localparam logic [7:0]  SIGN_BYTE = 8'h80;
   localparam logic [15:0] SIGN_WORD = 16'h8000;

   typedef enum logic [FORMAT_W-1:0] {
      FMT_S8    = 3'd0,
      FMT_U8    = 3'd1,
      FMT_S16LE = 3'd2,
      FMT_U16LE = 3'd3,
      FMT_S16BE = 3'd4,
      FMT_U16BE = 3'd5
   } format_type;

   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } direction_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIRECTION = 1'b0,
      CSR_FORMAT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      direction_type           direction;
      logic [FORMAT_W-1:0]     sample_format;
   } codec_cfg_type;

endpackage

[hdl/mulaw_pcm_format_converter.sv]
// channel  | ports                          | payload
// ---------+--------------------------------+---------------------------------
// req      | req_tvalid/tready/tdata/tlast  | tdata[15:0] sample_in, tlast last_in
// rsp      | rsp_tvalid/tready/tdata/tlast  | tdata[15:0] sample_out, tlast last_out
// csr      | csr_valid/ready/index/data     | index 0 direction, 1 sample_format
//
// one sample per cycle sustained while the receiver does not stall; from accept to
// result a sample passes the input register, conversion logic and result register
// synchronous active-high reset clears valids and both config registers
// a stalled result holds in the output register while the input register
// still takes one more beat; csr writes are always ready
module mulaw_pcm_format_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mlaw_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] sample_in
   input  logic                                req_tlast,   // last_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mlaw_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] sample_out
   output logic                                rsp_tlast,   // last_out
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mlaw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mlaw_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mlaw_pkg::*;

   codec_cfg_type        cfg_ff;
   logic                 in_valid_ff;
   logic [SAMPLE_W-1:0]  in_sample_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   logic [SAMPLE_W-1:0]  out_sample_ff;
   logic                 out_last_ff;
   logic [SAMPLE_W-1:0]  out_sample_in;
   logic                 advance;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction     <= DIR_ENCODE;
         cfg_ff.sample_format <= FMT_S8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIRECTION: cfg_ff.direction     <= direction_type'(csr_data[0]);
            CSR_FORMAT:    cfg_ff.sample_format <= csr_data[FORMAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata;
         in_last_ff   <= req_tlast;
      end
   end

   mlaw_codec u_codec (
      .cfg        (cfg_ff),
      .sample_in  (in_sample_ff),
      .sample_out (out_sample_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[hdl/mlaw_codec.sv]
module mlaw_codec (
   input  mlaw_pkg::codec_cfg_type          cfg,
   input  logic [mlaw_pkg::SAMPLE_W-1:0]    sample_in,
   output logic [mlaw_pkg::SAMPLE_W-1:0]    sample_out
);
   import mlaw_pkg::*;

   function automatic logic [15:0] swap16(input logic [15:0] w);
      swap16 = {w[7:0], w[15:8]};
   endfunction

   logic [15:0] enc_lin;
   logic        enc_sign;
   logic [15:0] enc_abs;
   logic [15:0] enc_mag;
   logic [2:0]  enc_exp;
   logic [15:0] enc_shift;
   logic [7:0]  enc_code;

   logic [7:0]  dec_u;
   logic [15:0] dec_t;
   logic [15:0] dec_lin;
   logic [15:0] dec_out;

   // linear input brought to signed 16-bit
   always_comb begin
      case (cfg.sample_format)
         FMT_S8:    enc_lin = {sample_in[7:0], 8'h00};
         FMT_U8:    enc_lin = {sample_in[7:0] ^ SIGN_BYTE, 8'h00};
         FMT_U16LE: enc_lin = sample_in ^ SIGN_WORD;
         FMT_S16BE: enc_lin = swap16(sample_in);
         FMT_U16BE: enc_lin = swap16(sample_in) ^ SIGN_WORD;
         default:   enc_lin = sample_in;
      endcase
   end

   always_comb begin
      enc_sign = enc_lin[15];
      enc_abs  = enc_sign ? (~enc_lin + 16'd1) : enc_lin;
      enc_mag  = ((enc_abs > MU_CLIP) ? MU_CLIP : enc_abs) + MU_BIAS;
      // segment is the highest set bit among bits 14..7
      enc_exp  = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (enc_mag[i+7]) begin
            enc_exp = 3'(i);
         end
      end
      enc_shift = enc_mag >> ({1'b0, enc_exp} + 4'd3);
      enc_code  = ~{enc_sign, enc_exp, enc_shift[3:0]};
   end

   always_comb begin
      dec_u   = ~sample_in[7:0];
      dec_t   = ({9'd0, dec_u[3:0], 3'd0} + MU_BIAS) << dec_u[6:4];
      dec_lin = dec_u[7] ? (MU_BIAS - dec_t) : (dec_t - MU_BIAS);
      case (cfg.sample_format)
         FMT_S8:    dec_out = {8'h00, dec_lin[15:8]};
         FMT_U8:    dec_out = {8'h00, dec_lin[15:8] ^ SIGN_BYTE};
         FMT_U16LE: dec_out = dec_lin ^ SIGN_WORD;
         FMT_S16BE: dec_out = swap16(dec_lin);
         FMT_U16BE: dec_out = swap16(dec_lin ^ SIGN_WORD);
         default:   dec_out = dec_lin;
      endcase
   end

   assign sample_out = (cfg.direction == DIR_DECODE) ? dec_out : {8'h00, enc_code};

endmodule

[hdl/mlaw_checker.sv]
module mlaw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [mlaw_pkg::SAMPLE_W-1:0]       rsp_tdata,
   input  logic                                rsp_tlast
);
   import mlaw_pkg::*;

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // every new result comes from an accepted request beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp beat without matching req beat");

   // with the output register empty the input side never stalls
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   // no result straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind mulaw_pcm_format_converter mlaw_checker u_mlaw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/tb_mulaw_pcm_format_converter.sv]
`timescale 1ns / 1ps

module tb_mulaw_pcm_format_converter;
   import mlaw_pkg::*;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } conv_sample_type;

   class mulaw_scoreboard;
      direction_type       dir;
      logic [FORMAT_W-1:0] fmt;
      conv_sample_type     expected_samples[$];
      int                  errors;

      function new();
         dir    = DIR_ENCODE;
         fmt    = FMT_S8;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DIRECTION: dir = direction_type'(val[0]);
            CSR_FORMAT:    fmt = val;
            default: ;
         endcase
      endfunction

      function logic [7:0] mu_compress(logic [15:0] lin);
         int         v;
         int         mag;
         int         seg;
         logic       sign;
         logic [3:0] mant;
         v    = $signed(lin);
         sign = 1'b0;
         if (v < 0) begin
            sign = 1'b1;
            v    = -v;
         end
         if (v > int'(MU_CLIP)) v = int'(MU_CLIP);
         mag = v + int'(MU_BIAS);
         seg = 7;
         // segment is the position of the leading one above bit 7
         while (seg > 0 && ((mag >> (seg + 7)) & 1) == 0) seg--;
         mant = 4'((mag >> (seg + 3)) & 15);
         return ~{sign, seg[2:0], mant};
      endfunction

      function logic [15:0] mu_expand(logic [7:0] code);
         logic [7:0] u;
         int         t;
         int         lin;
         u   = ~code;
         t   = ((int'(u[3:0]) << 3) + int'(MU_BIAS)) << u[6:4];
         lin = u[7] ? int'(MU_BIAS) - t : t - int'(MU_BIAS);
         return lin[15:0];
      endfunction

      function logic [15:0] convert_sample(logic [15:0] s);
         logic [7:0]  b;
         logic [15:0] lin;
         logic [15:0] r;
         b = s[7:0];
         if (dir == DIR_ENCODE) begin
            case (fmt)
               FMT_S8:    lin = {b, 8'h00};
               FMT_U8:    lin = {b ^ SIGN_BYTE, 8'h00};
               FMT_U16LE: lin = s ^ SIGN_WORD;
               FMT_S16BE: lin = {s[7:0], s[15:8]};
               FMT_U16BE: lin = {s[7:0], s[15:8]} ^ SIGN_WORD;
               default:   lin = s;
            endcase
            r = {8'h00, mu_compress(lin)};
         end else begin
            lin = mu_expand(b);
            case (fmt)
               FMT_S8:    r = {8'h00, lin[15:8]};
               FMT_U8:    r = {8'h00, lin[15:8] ^ SIGN_BYTE};
               FMT_U16LE: r = lin ^ SIGN_WORD;
               FMT_S16BE: r = {lin[7:0], lin[15:8]};
               FMT_U16BE: begin
                  lin = lin ^ SIGN_WORD;
                  r   = {lin[7:0], lin[15:8]};
               end
               default:   r = lin;
            endcase
         end
         return r;
      endfunction

      function void note_input(logic [15:0] s, logic last);
         conv_sample_type e;
         e.sample = convert_sample(s);
         e.last   = last;
         expected_samples.push_back(e);
      endfunction

      function void check_result(logic [15:0] s, logic last);
         conv_sample_type e;
         if (expected_samples.size() == 0) begin
            $error("unexpected result beat: sample_out %h last_out %b", s, last);
            errors++;
            return;
         end
         e = expected_samples.pop_front();
         if (s !== e.sample) begin
            $error("sample_out: expected %h, actual %h", e.sample, s);
            errors++;
         end
         if (last !== e.last) begin
            $error("last_out: expected %b, actual %b", e.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   mulaw_scoreboard sb = new();

   int burst_left = 0;
   int rx_left    = 0;
   int rx_mode    = 0;

   mulaw_pcm_format_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // receiver: stretches of full rate, random stalls and solid stalls
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(1, 30);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
         0, 1:    rsp_tready <= 1'b1;
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= 1'b0;
      endcase
   end

   task automatic send_sample(logic [15:0] s, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            req_tdata  = 16'($urandom);
            req_tlast  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_setting(direction_type dir, logic [FORMAT_W-1:0] fmt);
      wait_drained();
      csr_write(CSR_DIRECTION, {2'b00, dir});
      csr_write(CSR_FORMAT, fmt);
   endtask

   function automatic logic [15:0] random_sample();
      logic [15:0] s;
      s = 16'($urandom);
      case ($urandom_range(0, 7))
         // values around zero, full scale and the clip point
         0: s = {8'($urandom_range(0, 1) ? 8'h00 : 8'hFF), 8'($urandom)};
         1: s = {8'($urandom_range(0, 1) ? 8'h7F : 8'h80), 8'($urandom)};
         2: s = {8'($urandom), 8'($urandom_range(0, 1) ? 8'h7F : 8'h80)};
         default: ;
      endcase
      return s;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_setting(DIR_ENCODE, FMT_S16LE);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);   // most negative input
      send_sample(16'h8001, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd32635, 1'b0);
      send_sample(16'd32636, 1'b1);
      apply_setting(DIR_ENCODE, FMT_S8);
      send_sample(16'hAB80, 1'b0);   // upper byte ignored
      send_sample(16'h547F, 1'b1);
      apply_setting(DIR_ENCODE, FMT_U16BE);
      send_sample(16'h0080, 1'b0);
      send_sample(16'hFF7F, 1'b1);
      apply_setting(DIR_DECODE, FMT_S16LE);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h00FF, 1'b0);
      send_sample(16'hFF7F, 1'b0);
      send_sample(16'h5580, 1'b1);
      apply_setting(DIR_DECODE, FMT_U8);
      send_sample(16'hFF00, 1'b0);
      send_sample(16'h00FF, 1'b1);
      apply_setting(DIR_DECODE, FMT_U16BE);
      send_sample(16'h0001, 1'b0);
      apply_setting(DIR_DECODE, 3'd7);   // undefined code behaves as S16LE
      send_sample(16'h0042, 1'b1);
      apply_setting(DIR_ENCODE, 3'd6);
      send_sample(16'h1234, 1'b0);

      for (int phase = 0; phase < 24; phase++) begin
         if (phase < 16)
            apply_setting(direction_type'(phase[3]), phase[2:0]);
         else
            apply_setting(direction_type'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         for (int i = 0; i < 50; i++) begin
            if (phase == 5 && i == 25) begin
               req_tvalid = 1'b0;
               while (sb.pending() != 0) @(negedge clock);
            end
            send_sample(random_sample(), $urandom_range(0, 7) == 0);
         end
      end

      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
